// ===== rtl/lbp_pkg.sv =====
// Package for the 3x3 local binary pattern stream: channel payload types,
// register indexes, size defaults and the code function.
// No dependencies.
`default_nettype none

package lbp_pkg;

   // Default largest row length held by the line stores
   localparam int MAX_WIDTH_DEFAULT = 1024;

   // Field widths
   localparam int PIXEL_WIDTH  = 8;
   localparam int IMG_W_WIDTH  = 11;
   localparam int IMG_H_WIDTH  = 16;
   localparam int CSR_DATA_WIDTH = 16;

   // Configuration register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Reset values of the configuration registers
   localparam logic [IMG_W_WIDTH-1:0] IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [IMG_H_WIDTH-1:0] IMAGE_HEIGHT_RESET = 16'd480;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic                   frame_start;
   } req_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] code;
      logic                   row_end;
      logic                   frame_end;
   } rsp_type;

   // One pattern bit per neighbour, set when the centre is not above it.
   // Neighbours clockwise from top-left, top-left in bit 0.
   function automatic logic [7:0] lbp_code(
      input logic [PIXEL_WIDTH-1:0] centre,
      input logic [PIXEL_WIDTH-1:0] top_left,
      input logic [PIXEL_WIDTH-1:0] top,
      input logic [PIXEL_WIDTH-1:0] top_right,
      input logic [PIXEL_WIDTH-1:0] right,
      input logic [PIXEL_WIDTH-1:0] bottom_right,
      input logic [PIXEL_WIDTH-1:0] bottom,
      input logic [PIXEL_WIDTH-1:0] bottom_left,
      input logic [PIXEL_WIDTH-1:0] left
   );
      logic [7:0] code;
      code[0] = (centre <= top_left);
      code[1] = (centre <= top);
      code[2] = (centre <= top_right);
      code[3] = (centre <= right);
      code[4] = (centre <= bottom_right);
      code[5] = (centre <= bottom);
      code[6] = (centre <= bottom_left);
      code[7] = (centre <= left);
      return code;
   endfunction

endpackage : lbp_pkg

`default_nettype wire

// ===== rtl/lbp_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read
// data that returns the old contents on a same-address write. No dependencies.
`default_nettype none

module lbp_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]    wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Read old data, then write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule : lbp_ram

`default_nettype wire

// ===== rtl/lbp_out_buf.sv =====
// Three-entry result buffer between the code stage and the result channel.
// Depends on lbp_pkg for the result payload type.
`default_nettype none

module lbp_out_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lbp_pkg::rsp_type push_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      lbp_pkg::rsp_type rsp_data,
   output      logic [1:0]       fill
);

   localparam int           DEPTH    = 3;
   localparam logic [1:0]   LAST_PTR = 2'(DEPTH - 1);

   lbp_pkg::rsp_type entry_ff [DEPTH];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             pop;

   assign pop       = (count_ff != 2'd0) && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign fill      = count_ff;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : lbp_out_buf

`default_nettype wire

// ===== rtl/lbp_3x3_code_stream.sv =====
// Top level of the 3x3 local binary pattern stream: counters, line store
// RAMs, window and code stage. Depends on lbp_pkg, lbp_ram and lbp_out_buf.
`default_nettype none

// Takes one 8-bit grayscale pixel per clock in raster order while req_ready
// is high and returns one 8-bit LBP code per interior pixel, (width-2) x
// (height-2) codes a frame, row_end and frame_end marking the last code of a
// row and of a frame. Sustained rate is one pixel per clock while rsp_ready
// is high. The two rows above are read from the line store RAMs in the
// cycle of acceptance and written back, shifted, in the next cycle, with a
// bypass when the same column is read again at once. A three-entry result
// buffer lets pixels keep flowing while a code waits. The line stores need
// no clearing after reset. image_width is taken as [3, MAX_WIDTH] and
// image_height as at least 3; write them only while idle.
module lbp_3x3_code_stream #(
   parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire lbp_pkg::req_type                     req_data,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      lbp_pkg::rsp_type                     rsp_data,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic                                 csr_index,
   input  wire logic [lbp_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int PW = lbp_pkg::PIXEL_WIDTH;
   localparam int HW = lbp_pkg::IMG_H_WIDTH;
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = (CW + 1 > lbp_pkg::IMG_W_WIDTH) ? CW + 1 : lbp_pkg::IMG_W_WIDTH;

   // Configuration registers
   logic [lbp_pkg::IMG_W_WIDTH-1:0] image_width_ff;
   logic [HW-1:0]                   image_height_ff;

   // Position counters
   logic [CW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;

   // Code stage
   logic          s1_valid_ff;
   logic          s1_emit_ff;
   logic          s1_last_col_ff;
   logic          s1_last_row_ff;
   logic [PW-1:0] s1_px_ff;
   logic [CW-1:0] s1_col_ff;
   logic          byp_ff;
   logic [PW-1:0] byp_up_ff;
   logic [PW-1:0] byp_mid_ff;
   logic [PW-1:0] win_ff [6];

   logic          accept;
   logic [CW-1:0] col_cur;
   logic [HW-1:0] row_cur;
   logic [LW-1:0] width_ext, width_eff, width_last;
   logic [HW-1:0] height_eff, height_last;
   logic          last_col, last_row, emit;
   logic [PW-1:0] up_rd, mid_rd, up_val, mid_val;
   logic [2:0]    pending;
   logic [1:0]    buf_fill;
   lbp_pkg::rsp_type result;

   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= lbp_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= lbp_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            lbp_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[lbp_pkg::IMG_W_WIDTH-1:0];
            end
            lbp_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[HW-1:0];
            end
            default: begin
               image_width_ff <= image_width_ff;
            end
         endcase
      end
   end

   // Saturate the frame size
   always_comb begin
      width_ext = LW'(image_width_ff);
      if (width_ext < LW'(3)) begin
         width_eff = LW'(3);
      end else if (width_ext > LW'(MAX_WIDTH)) begin
         width_eff = LW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      width_last  = width_eff - LW'(1);
      height_eff  = (image_height_ff < HW'(3)) ? HW'(3) : image_height_ff;
      height_last = height_eff - HW'(1);
   end

   // Take a pixel while the buffer can absorb everything in flight
   assign pending   = 3'(buf_fill) + 3'(s1_valid_ff && s1_emit_ff);
   assign req_ready = (pending <= 3'd2);
   assign accept    = req_valid && req_ready;

   // Position of the incoming pixel
   always_comb begin
      col_cur  = req_data.frame_start ? '0 : col_ff;
      row_cur  = req_data.frame_start ? '0 : row_ff;
      last_col = (LW'(col_cur) >= width_last);
      last_row = (row_cur >= height_last);
      emit     = (row_cur >= HW'(2)) && (col_cur >= CW'(2));
      col_in   = last_col ? '0 : col_cur + CW'(1);
      if (!last_col) begin
         row_in = row_cur;
      end else if (last_row) begin
         row_in = '0;
      end else begin
         row_in = row_cur + HW'(1);
      end
   end

   // Advance counters and the code stage
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            byp_ff <= s1_valid_ff && (s1_col_ff == col_cur);
         end
      end
   end

   // Hold the stage payload and the bypass copy of the column being written
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff     <= emit;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
         s1_px_ff       <= req_data.pixel;
         s1_col_ff      <= col_cur;
         byp_up_ff      <= mid_val;
         byp_mid_ff     <= s1_px_ff;
      end
   end

   // Line stores: upper holds row r-2, middle holds row r-1
   lbp_ram #(
      .DATA_WIDTH (PW),
      .DEPTH      (MAX_WIDTH)
   ) u_ram_upper (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (mid_val),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (up_rd)
   );

   lbp_ram #(
      .DATA_WIDTH (PW),
      .DEPTH      (MAX_WIDTH)
   ) u_ram_middle (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (mid_rd)
   );

   // Forward the write still landing when the same column was read
   assign up_val  = byp_ff ? byp_up_ff  : up_rd;
   assign mid_val = byp_ff ? byp_mid_ff : mid_rd;

   // Shift the window one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= up_val;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= mid_val;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= s1_px_ff;
      end
   end

   // Form the code around the middle-row centre
   always_comb begin
      result.code = lbp_pkg::lbp_code(win_ff[3], win_ff[0], win_ff[1], up_val,
                                      mid_val, s1_px_ff, win_ff[5], win_ff[4],
                                      win_ff[2]);
      result.row_end   = s1_last_col_ff;
      result.frame_end = s1_last_col_ff && s1_last_row_ff;
   end

   lbp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff && s1_emit_ff),
      .push_data (result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .fill      (buf_fill)
   );

endmodule : lbp_3x3_code_stream

`default_nettype wire
